@@ design/lpmt_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lpmt_pkg
// Shared types, codes and lookup functions for the length-prefixed message
// tally: parse phases, message kinds, frame status codes and the event that
// travels from the parser to the accumulator.
// ---------------------------------------------------------------------------
package lpmt_pkg;

    // event queue between parser and accumulator
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    // type letters
    localparam logic [7:0] LetterAdd     = 8'h41; // 'A'
    localparam logic [7:0] LetterDelete  = 8'h44; // 'D'
    localparam logic [7:0] LetterExecute = 8'h45; // 'E'
    localparam logic [7:0] LetterReplace = 8'h55; // 'U'

    typedef enum logic [1:0] {
        PHASE_LEN_HIGH = 2'd0,
        PHASE_LEN_LOW  = 2'd1,
        PHASE_BODY     = 2'd2,
        PHASE_STOPPED  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        KIND_ADD     = 3'd0,
        KIND_DELETE  = 3'd1,
        KIND_EXECUTE = 3'd2,
        KIND_REPLACE = 3'd3,
        KIND_OTHER   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_ZERO  = 2'd1,
        STATUS_TRUNC = 2'd2
    } t_status;

    // one result event from the parser
    typedef struct packed {
        t_kind      kind;
        t_status    status;
        logic       sum_en;
        logic [7:0] sum_byte;
    } t_evt;

    // type letter to message kind
    function automatic t_kind kind_of(input logic [7:0] letter);
        t_kind k;
        case (letter)
            LetterAdd:     k = KIND_ADD;
            LetterDelete:  k = KIND_DELETE;
            LetterExecute: k = KIND_EXECUTE;
            LetterReplace: k = KIND_REPLACE;
            default:       k = KIND_OTHER;
        endcase
        return k;
    endfunction

    // body index of the checksum byte for a kind
    function automatic logic [15:0] pick_index(input t_kind k);
        logic [15:0] idx;
        case (k)
            KIND_ADD:     idx = 16'd19;
            KIND_DELETE:  idx = 16'd5;
            KIND_EXECUTE: idx = 16'd6;
            KIND_REPLACE: idx = 16'd7;
            default:      idx = 16'd0;
        endcase
        return idx;
    endfunction

    // minimum frame length for the checksum to count
    function automatic logic [15:0] min_length(input t_kind k);
        logic [15:0] len;
        case (k)
            KIND_ADD:     len = 16'd37;
            KIND_DELETE:  len = 16'd19;
            KIND_EXECUTE: len = 16'd31;
            KIND_REPLACE: len = 16'd35;
            default:      len = 16'hFFFF;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

@@ design/lpmt_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lpmt_front
// Frame parser: walks the length prefix and body of each frame one byte per
// transaction, captures the type letter and checksum byte, and pushes one
// event per finished or stopped frame into the event queue.
// ---------------------------------------------------------------------------
module lpmt_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_accept,
    input  wire  [7:0]       i_byte,
    input  wire              i_last,
    output logic             o_push,
    output lpmt_pkg::t_evt   o_evt
);

    lpmt_pkg::t_phase r_phase, n_phase;
    logic [15:0]      r_len, n_len;
    logic [15:0]      r_pos, n_pos;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_pick, n_pick;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lpmt_pkg::PHASE_LEN_HIGH;
            r_len   <= '0;
            r_pos   <= '0;
            r_type  <= '0;
            r_pick  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_type  <= n_type;
            r_pick  <= n_pick;
        end
    end

    // next state and event
    always_comb begin
        logic [15:0]     full_len;
        lpmt_pkg::t_kind kind;
        logic            is_last;
        logic            known;

        n_phase  = r_phase;
        n_len    = r_len;
        n_pos    = r_pos;
        n_type   = r_type;
        n_pick   = r_pick;
        o_push   = 1'b0;
        o_evt    = '{kind: lpmt_pkg::KIND_OTHER, status: lpmt_pkg::STATUS_TRUNC,
                     sum_en: 1'b0, sum_byte: 8'h00};

        full_len = {r_len[15:8], i_byte};
        n_type   = (r_pos == 16'd0) ? i_byte : r_type;
        kind     = lpmt_pkg::kind_of(n_type);
        known    = (kind != lpmt_pkg::KIND_OTHER);
        n_pick   = (known && r_pos == lpmt_pkg::pick_index(kind)) ? i_byte : r_pick;
        is_last  = (({1'b0, r_pos} + 17'd1) == {1'b0, r_len});

        case (r_phase)
            lpmt_pkg::PHASE_LEN_HIGH: begin
                n_type = r_type;
                n_pick = r_pick;
                n_len  = {i_byte, 8'h00};
                if (i_last) begin
                    n_phase = lpmt_pkg::PHASE_STOPPED;
                    o_push  = 1'b1;
                end else begin
                    n_phase = lpmt_pkg::PHASE_LEN_LOW;
                end
            end
            lpmt_pkg::PHASE_LEN_LOW: begin
                n_type = r_type;
                n_pick = r_pick;
                n_len  = full_len;
                if (full_len == 16'd0) begin
                    n_phase      = lpmt_pkg::PHASE_STOPPED;
                    o_push       = 1'b1;
                    o_evt.status = lpmt_pkg::STATUS_ZERO;
                end else if (i_last) begin
                    n_phase = lpmt_pkg::PHASE_STOPPED;
                    o_push  = 1'b1;
                end else begin
                    n_pos   = 16'd0;
                    n_phase = lpmt_pkg::PHASE_BODY;
                end
            end
            lpmt_pkg::PHASE_BODY: begin
                if (is_last) begin
                    o_push         = 1'b1;
                    o_evt.kind     = kind;
                    o_evt.status   = lpmt_pkg::STATUS_DONE;
                    o_evt.sum_en   = known && (r_len >= lpmt_pkg::min_length(kind));
                    o_evt.sum_byte = n_pick;
                    n_phase        = i_last ? lpmt_pkg::PHASE_STOPPED
                                            : lpmt_pkg::PHASE_LEN_HIGH;
                end else begin
                    n_pos = r_pos + 16'd1;
                    if (i_last) begin
                        n_phase = lpmt_pkg::PHASE_STOPPED;
                        o_push  = 1'b1;
                    end
                end
            end
            default: begin
                // stopped: bytes are swallowed until reset
                n_type = r_type;
                n_pick = r_pick;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ design/lpmt_queue.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lpmt_queue
// Small event queue in flip-flops between parser and accumulator, so that
// the byte side keeps flowing while a result waits on the output side.
// ---------------------------------------------------------------------------
module lpmt_queue (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  wire lpmt_pkg::t_evt   i_evt,
    input  wire                   i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output lpmt_pkg::t_evt        o_evt
);

    lpmt_pkg::t_evt                   r_mem [lpmt_pkg::QueueDepth];
    logic [lpmt_pkg::QueuePtrW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [lpmt_pkg::QueueCntW-1:0]   r_count, n_count;

    assign o_full  = (r_count == lpmt_pkg::QueueCntW'(lpmt_pkg::QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_evt   = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + lpmt_pkg::QueueCntW'(1);
            2'b01:   n_count = r_count - lpmt_pkg::QueueCntW'(1);
            default: n_count = r_count;
        endcase
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + lpmt_pkg::QueuePtrW'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + lpmt_pkg::QueuePtrW'(1);
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_evt;
    end

endmodule
`default_nettype wire

@@ design/lpmt_back.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lpmt_back
// Accumulator: takes one event from the queue, bumps the per-kind and total
// counters and the checksum for a finished frame, and holds the result in the
// output register until the downstream side takes it.
// ---------------------------------------------------------------------------
module lpmt_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_evt_valid,
    input  wire lpmt_pkg::t_evt   i_evt,
    output logic                  o_pop,
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    output logic [383:0]          o_m_tdata,
    output logic [4:0]            o_m_tuser
);

    logic [63:0]       r_add, r_delete, r_execute, r_replace, r_total, r_sum;
    logic              r_valid;
    lpmt_pkg::t_kind   r_kind;
    lpmt_pkg::t_status r_status;
    logic              done;
    logic [63:0]       sum_inc;

    // pop when the output slot is free or being taken
    assign o_pop   = i_evt_valid && (!r_valid || i_m_tready);
    assign done    = (i_evt.status == lpmt_pkg::STATUS_DONE);
    assign sum_inc = {{56{(i_evt.kind == lpmt_pkg::KIND_ADD) && i_evt.sum_byte[7]}},
                      i_evt.sum_byte};

    // counters change only when a new result is loaded, so they are the payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add     <= '0;
            r_delete  <= '0;
            r_execute <= '0;
            r_replace <= '0;
            r_total   <= '0;
            r_sum     <= '0;
        end else if (o_pop && done) begin
            if (i_evt.kind == lpmt_pkg::KIND_ADD)     r_add     <= r_add + 64'd1;
            if (i_evt.kind == lpmt_pkg::KIND_DELETE)  r_delete  <= r_delete + 64'd1;
            if (i_evt.kind == lpmt_pkg::KIND_EXECUTE) r_execute <= r_execute + 64'd1;
            if (i_evt.kind == lpmt_pkg::KIND_REPLACE) r_replace <= r_replace + 64'd1;
            r_total <= r_total + 64'd1;
            if (i_evt.sum_en) r_sum <= r_sum + sum_inc;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_kind   <= lpmt_pkg::KIND_OTHER;
            r_status <= lpmt_pkg::STATUS_DONE;
        end else if (o_pop) begin
            r_valid  <= 1'b1;
            r_kind   <= i_evt.kind;
            r_status <= i_evt.status;
        end else if (i_m_tready) begin
            r_valid  <= 1'b0;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_sum, r_total, r_replace, r_execute, r_delete, r_add};
    assign o_m_tuser  = {r_status, r_kind};

endmodule
`default_nettype wire

@@ design/length_prefixed_message_tally.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// length_prefixed_message_tally
// Counts add, delete, execute and replace messages in a length-prefixed byte
// stream and keeps a 64-bit checksum of one chosen body byte per message.
// ---------------------------------------------------------------------------
//  channel   direction  carries
//  s (in)    slave      one stream byte per transaction, tlast = end of input
//  m (out)   master     one result per finished frame or stop condition
//
//  One byte is taken per cycle while the queue has room; a result passes
//  through the event queue and the output register to the master side. The
//  front parser and the back accumulator are parted by a four-entry event
//  queue; the slave side stalls only when that queue is full. After a zero
//  length or any tlast the parser swallows all further bytes until reset.
//  Reset clears parser state, counters and checksum.
// ---------------------------------------------------------------------------
module length_prefixed_message_tally (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [7:0]   i_s_tdata,   // data_byte
    input  wire          i_s_tlast,   // end_of_input
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [383:0] o_m_tdata,   // add_total, delete_total, execute_total,
                                      // replace_total, message_total, running_sum
    output logic [4:0]   o_m_tuser    // message_kind, frame_status
);

    logic           accept;
    logic           push;
    logic           pop;
    logic           full;
    logic           evt_valid;
    lpmt_pkg::t_evt front_evt;
    lpmt_pkg::t_evt queue_evt;

    assign o_s_tready = !full;
    assign accept     = i_s_tvalid && !full;

    // frame parser
    lpmt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_push   (push),
        .o_evt    (front_evt)
    );

    // event queue
    lpmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && accept),
        .i_evt   (front_evt),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (evt_valid),
        .o_evt   (queue_evt)
    );

    // counters, checksum and output register
    lpmt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (evt_valid),
        .i_evt       (queue_evt),
        .o_pop       (pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule
`default_nettype wire
